[src/bvi_pkg.sv]
// Shared types, constants and the control store for the bounded vector block.
package bvi_pkg;

  // Storage depth and field widths
  localparam int DEPTH = 32;
  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = 6;
  localparam int VAL_W = 32;
  localparam int PC_W  = 4;

  localparam logic [CNT_W-1:0] START_CAP = CNT_W'(2);

  // Action codes
  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_INSERT = 2'd2,
    ACT_DUMP   = 2'd3
  } action_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  // Datapath micro-operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_FETCH,
    OP_APPEND,
    OP_REMOVE,
    OP_INS_CHK,
    OP_SH_RD,
    OP_SH_WR,
    OP_INS_WR,
    OP_DUMP_INIT,
    OP_RD_IDX,
    OP_EMIT_ELEM,
    OP_EMIT_STAT
  } op_t;

  // Hold conditions
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_IN,
    STALL_OUT
  } stall_t;

  // Branch conditions
  typedef enum logic [2:0] {
    C_TRUE,
    C_INS_ERR,
    C_IDX_EQ_POS,
    C_CNT_ZERO,
    C_MORE
  } cond_t;

  // One control word
  typedef struct packed {
    op_t             op;
    stall_t          stall;
    cond_t           cond;
    logic            dispatch;
    logic [PC_W-1:0] tgt_t;
    logic [PC_W-1:0] tgt_f;
  } ctl_word_t;

  // Flags from datapath to sequencer
  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic ins_err;
    logic idx_eq_pos;
    logic cnt_zero;
    logic more;
  } cond_flags_t;

  // Program step addresses
  localparam logic [PC_W-1:0] STEP_FETCH   = PC_W'(0);
  localparam logic [PC_W-1:0] STEP_APPEND  = PC_W'(1);
  localparam logic [PC_W-1:0] STEP_REMOVE  = PC_W'(2);
  localparam logic [PC_W-1:0] STEP_INS_CHK = PC_W'(3);
  localparam logic [PC_W-1:0] STEP_SH_TST  = PC_W'(4);
  localparam logic [PC_W-1:0] STEP_SH_WR   = PC_W'(5);
  localparam logic [PC_W-1:0] STEP_INS_WR  = PC_W'(6);
  localparam logic [PC_W-1:0] STEP_DMP_CHK = PC_W'(7);
  localparam logic [PC_W-1:0] STEP_DMP_RD  = PC_W'(8);
  localparam logic [PC_W-1:0] STEP_DMP_EM  = PC_W'(9);
  localparam logic [PC_W-1:0] STEP_STAT    = PC_W'(10);

  // Entry step for each action
  function automatic logic [PC_W-1:0] dispatch_target(input action_t act);
    logic [PC_W-1:0] t;
    unique case (act)
      ACT_APPEND: t = STEP_APPEND;
      ACT_REMOVE: t = STEP_REMOVE;
      ACT_INSERT: t = STEP_INS_CHK;
      default:    t = STEP_DMP_CHK;
    endcase
    return t;
  endfunction

  // Control store
  function automatic ctl_word_t rom_word(input logic [PC_W-1:0] pc);
    ctl_word_t w;
    unique case (pc)
      STEP_FETCH:   w = '{OP_FETCH,     STALL_IN,   C_TRUE,       1'b1, STEP_FETCH,  STEP_FETCH};
      STEP_APPEND:  w = '{OP_APPEND,    STALL_NONE, C_TRUE,       1'b0, STEP_STAT,   STEP_STAT};
      STEP_REMOVE:  w = '{OP_REMOVE,    STALL_NONE, C_TRUE,       1'b0, STEP_STAT,   STEP_STAT};
      STEP_INS_CHK: w = '{OP_INS_CHK,   STALL_NONE, C_INS_ERR,    1'b0, STEP_STAT,   STEP_SH_TST};
      STEP_SH_TST:  w = '{OP_SH_RD,     STALL_NONE, C_IDX_EQ_POS, 1'b0, STEP_INS_WR, STEP_SH_WR};
      STEP_SH_WR:   w = '{OP_SH_WR,     STALL_NONE, C_TRUE,       1'b0, STEP_SH_TST, STEP_SH_TST};
      STEP_INS_WR:  w = '{OP_INS_WR,    STALL_NONE, C_TRUE,       1'b0, STEP_STAT,   STEP_STAT};
      STEP_DMP_CHK: w = '{OP_DUMP_INIT, STALL_NONE, C_CNT_ZERO,   1'b0, STEP_STAT,   STEP_DMP_RD};
      STEP_DMP_RD:  w = '{OP_RD_IDX,    STALL_NONE, C_TRUE,       1'b0, STEP_DMP_EM, STEP_DMP_EM};
      STEP_DMP_EM:  w = '{OP_EMIT_ELEM, STALL_OUT,  C_MORE,       1'b0, STEP_DMP_RD, STEP_FETCH};
      STEP_STAT:    w = '{OP_EMIT_STAT, STALL_OUT,  C_TRUE,       1'b0, STEP_FETCH,  STEP_FETCH};
      default:      w = '{OP_NOP,       STALL_NONE, C_TRUE,       1'b0, STEP_FETCH,  STEP_FETCH};
    endcase
    return w;
  endfunction

endpackage

[src/bvi_seq.sv]
// Microprogram sequencer: step counter, control store lookup and branching.
module bvi_seq (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bvi_pkg::cond_flags_t   flags,
  input  bvi_pkg::action_t       act,
  output bvi_pkg::ctl_word_t     ctl,
  output logic                   go
);
  import bvi_pkg::*;

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  logic            cond_val;

  assign ctl = rom_word(pc_r);

  // Hold the step while the channel it needs is not ready
  always_comb begin
    unique case (ctl.stall)
      STALL_IN:  go = flags.in_valid;
      STALL_OUT: go = flags.out_free;
      default:   go = 1'b1;
    endcase
  end

  // Branch condition select
  always_comb begin
    unique case (ctl.cond)
      C_INS_ERR:    cond_val = flags.ins_err;
      C_IDX_EQ_POS: cond_val = flags.idx_eq_pos;
      C_CNT_ZERO:   cond_val = flags.cnt_zero;
      C_MORE:       cond_val = flags.more;
      default:      cond_val = 1'b1;
    endcase
  end

  // Next step
  always_comb begin
    if (!go) begin
      pc_nxt = pc_r;
    end else if (ctl.dispatch) begin
      pc_nxt = dispatch_target(act);
    end else begin
      pc_nxt = cond_val ? ctl.tgt_t : ctl.tgt_f;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_FETCH;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

[src/bvi_dpath.sv]
// Datapath: element memory, count and capacity registers, result register.
module bvi_dpath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bvi_pkg::ctl_word_t          ctl,
  input  logic                        go,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bvi_pkg::CNT_W-1:0]   in_position,
  input  logic signed [bvi_pkg::VAL_W-1:0] in_value,
  output bvi_pkg::cond_flags_t        flags,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [bvi_pkg::VAL_W-1:0] out_element,
  output logic                        out_element_valid,
  output logic [bvi_pkg::CNT_W-1:0]   out_count,
  output logic [bvi_pkg::CNT_W-1:0]   out_capacity_now,
  output logic                        out_is_empty,
  output logic [1:0]                  out_status,
  output logic                        out_last
);
  import bvi_pkg::*;

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rd_r;

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cap_r;
  logic [CNT_W-1:0] idx_r;
  logic [CNT_W-1:0] pos_r;
  logic [VAL_W-1:0] val_r;
  status_t          status_r;
  logic             out_valid_r;

  logic             do_op;
  logic             at_cap;
  logic             add_full;
  logic             bad_pos;
  logic [CNT_W:0]   cap_dbl;
  logic [CNT_W-1:0] idx_dec;
  logic [CNT_W-1:0] idx_inc;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] cnt_dec;
  logic             add_ok;

  assign do_op   = go;
  assign in_ready = (ctl.op == OP_FETCH);

  // Room check: full when at capacity and doubling would pass the depth, or when the count has reached the depth
  assign at_cap   = (cnt_r == cap_r);
  assign cap_dbl  = {cap_r, 1'b0};
  assign add_full = (at_cap && (cap_dbl > (CNT_W+1)'(DEPTH))) ||
                    ({1'b0, cnt_r} >= (CNT_W+1)'(DEPTH));
  assign bad_pos  = (pos_r > cnt_r);
  assign add_ok   = !add_full;
  assign idx_dec  = idx_r - CNT_W'(1);
  assign idx_inc  = idx_r + CNT_W'(1);
  assign cnt_inc  = cnt_r + CNT_W'(1);
  assign cnt_dec  = cnt_r - CNT_W'(1);

  // Flags for the sequencer
  assign flags.in_valid   = in_valid;
  assign flags.out_free   = !out_valid_r || out_ready;
  assign flags.ins_err    = bad_pos || add_full;
  assign flags.idx_eq_pos = (idx_r == pos_r);
  assign flags.cnt_zero   = (cnt_r == '0);
  assign flags.more       = (idx_inc != cnt_r);

  // Count, capacity and result-valid control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      cap_r       <= START_CAP;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (do_op) begin
        case (ctl.op)
          OP_APPEND: begin
            if (add_ok) begin
              cnt_r <= cnt_inc;
              if (at_cap) begin
                cap_r <= cap_dbl[CNT_W-1:0];
              end
            end
          end
          OP_REMOVE: begin
            if (cnt_r != '0) begin
              cnt_r <= cnt_dec;
            end
          end
          OP_INS_CHK: begin
            if (!bad_pos && add_ok && at_cap) begin
              cap_r <= cap_dbl[CNT_W-1:0];
            end
          end
          OP_INS_WR: cnt_r <= cnt_inc;
          OP_EMIT_ELEM, OP_EMIT_STAT: out_valid_r <= 1'b1;
          default: ;
        endcase
      end
    end
  end

  // Item latches, loop index and status
  always_ff @(posedge clk) begin
    if (do_op) begin
      case (ctl.op)
        OP_FETCH: begin
          pos_r    <= in_position;
          val_r    <= in_value;
          status_r <= ST_OK;
        end
        OP_APPEND: begin
          if (add_full) begin
            status_r <= ST_FULL;
          end
        end
        OP_REMOVE: begin
          if (cnt_r == '0) begin
            status_r <= ST_EMPTY;
          end
        end
        OP_INS_CHK: begin
          if (bad_pos) begin
            status_r <= ST_BADPOS;
          end else if (add_full) begin
            status_r <= ST_FULL;
          end
          idx_r <= cnt_r;
        end
        OP_SH_WR:     idx_r <= idx_dec;
        OP_DUMP_INIT: idx_r <= '0;
        OP_EMIT_ELEM: idx_r <= idx_inc;
        default: ;
      endcase
    end
  end

  // Element memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (do_op) begin
      case (ctl.op)
        OP_APPEND: begin
          if (add_ok) begin
            mem[cnt_r[AW-1:0]] <= val_r;
          end
        end
        OP_SH_WR:  mem[idx_r[AW-1:0]] <= rd_r;
        OP_INS_WR: mem[pos_r[AW-1:0]] <= val_r;
        OP_SH_RD:  rd_r <= mem[idx_dec[AW-1:0]];
        OP_RD_IDX: rd_r <= mem[idx_r[AW-1:0]];
        default: ;
      endcase
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (do_op && (ctl.op == OP_EMIT_ELEM)) begin
      out_element       <= rd_r;
      out_element_valid <= 1'b1;
      out_count         <= cnt_r;
      out_capacity_now  <= cap_r;
      out_is_empty      <= 1'b0;
      out_status        <= ST_OK;
      out_last          <= !flags.more;
    end else if (do_op && (ctl.op == OP_EMIT_STAT)) begin
      out_element       <= '0;
      out_element_valid <= 1'b0;
      out_count         <= cnt_r;
      out_capacity_now  <= cap_r;
      out_is_empty      <= (cnt_r == '0);
      out_status        <= status_r;
      out_last          <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[src/bounded_vector_insert_append.sv]
// Bounded ordered vector of signed 32-bit elements (append, remove last, insert, dump).
//
// A short microprogram drives one element memory with one write and one read
// port. Each item runs to its end before the next input is accepted. An insert
// shifts each element above the position up by one, with one memory read and
// one write per shifted element; a bad position or a full vector skips the
// shift. A dump does one read and one result per element. A result waiting at
// the output holds the program only at the steps that emit.
// Capacity starts at 2 and doubles up to 32; an add on a full vector at that
// limit reports full and changes nothing. The element memory is not cleared;
// only written entries are ever read.
module bounded_vector_insert_append (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_action,
  input  logic [bvi_pkg::CNT_W-1:0]        in_position,
  input  logic signed [bvi_pkg::VAL_W-1:0] in_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [bvi_pkg::VAL_W-1:0] out_element,
  output logic                             out_element_valid,
  output logic [bvi_pkg::CNT_W-1:0]        out_count,
  output logic [bvi_pkg::CNT_W-1:0]        out_capacity_now,
  output logic                             out_is_empty,
  output logic [1:0]                       out_status,
  output logic                             out_last
);
  import bvi_pkg::*;

  ctl_word_t   ctl;
  logic        go;
  cond_flags_t flags;

  // Sequencer
  bvi_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .act   (action_t'(in_action)),
    .ctl   (ctl),
    .go    (go)
  );

  // Datapath
  bvi_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .go                (go),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_position       (in_position),
    .in_value          (in_value),
    .flags             (flags),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_element       (out_element),
    .out_element_valid (out_element_valid),
    .out_count         (out_count),
    .out_capacity_now  (out_capacity_now),
    .out_is_empty      (out_is_empty),
    .out_status        (out_status),
    .out_last          (out_last)
  );

endmodule

[src/bvi_chk.sv]
// Port-level checker for the bounded vector block, with its bind statement.
module bvi_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [bvi_pkg::VAL_W-1:0] out_element,
  input logic                             out_element_valid,
  input logic [bvi_pkg::CNT_W-1:0]        out_count,
  input logic                             out_is_empty,
  input logic [1:0]                       out_status,
  input logic                             out_last
);
  import bvi_pkg::*;

  // Empty flag tracks the reported count
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_count == '0)))
    else $error("is_empty disagrees with count");

  // Status results are always the final result of their action
  a_stat_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_element_valid) |-> out_last)
    else $error("status result without last");

  // Dumped elements carry ok status and a nonzero count
  a_elem_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_element_valid) |-> ((out_status == ST_OK) && !out_is_empty))
    else $error("dumped element with bad status or empty count");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_element) &&
                                   $stable(out_last) && $stable(out_status)))
    else $error("result changed while stalled");

endmodule

bind bounded_vector_insert_append bvi_chk u_bvi_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_element       (out_element),
  .out_element_valid (out_element_valid),
  .out_count         (out_count),
  .out_is_empty      (out_is_empty),
  .out_status        (out_status),
  .out_last          (out_last)
);

[sim/testbench.sv]
// Self-checking testbench for the bounded vector block: append, remove, insert and dump.
`timescale 1ns / 100ps

module testbench;
  import bvi_pkg::*;

  // One result as the block should emit it
  typedef struct {
    logic signed [VAL_W-1:0] element;
    logic                    element_valid;
    logic [CNT_W-1:0]        count;
    logic [CNT_W-1:0]        capacity;
    logic                    is_empty;
    status_t                 status;
    logic                    last;
  } vec_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [1:0]              in_action = ACT_APPEND;
  logic [CNT_W-1:0]        in_position = '0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [VAL_W-1:0] out_element;
  logic                    out_element_valid;
  logic [CNT_W-1:0]        out_count;
  logic [CNT_W-1:0]        out_capacity_now;
  logic                    out_is_empty;
  logic [1:0]              out_status;
  logic                    out_last;

  // Shadow copy of the vector contents
  logic signed [VAL_W-1:0] shadow_mem [DEPTH];
  int unsigned             shadow_count = 0;
  int unsigned             shadow_cap = 2;

  vec_result_t pending_results[$];
  int          error_count = 0;
  int          in_idle_pct = 0;
  int          out_stall_pct = 0;
  int          hold_left = 0;

  bounded_vector_insert_append uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_position       (in_position),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_element       (out_element),
    .out_element_valid (out_element_valid),
    .out_count         (out_count),
    .out_capacity_now  (out_capacity_now),
    .out_is_empty      (out_is_empty),
    .out_status        (out_status),
    .out_last          (out_last)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < 40)
      $display("%0t ns: %s mismatch: got %0h, want %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Capacity doubling rule; false when the vector cannot take one more
  function automatic bit shadow_grow();
    if (shadow_count < shadow_cap) return 1'b1;
    if (shadow_cap * 2 > DEPTH) return 1'b0;
    shadow_cap = shadow_cap * 2;
    return 1'b1;
  endfunction

  function automatic vec_result_t make_result(input logic signed [VAL_W-1:0] elem,
                                              input logic valid, input status_t st,
                                              input logic last);
    vec_result_t r;
    r.element       = elem;
    r.element_valid = valid;
    r.count         = CNT_W'(shadow_count);
    r.capacity      = CNT_W'(shadow_cap);
    r.is_empty      = (shadow_count == 0);
    r.status        = st;
    r.last          = last;
    return r;
  endfunction

  // Apply one action to the shadow vector and queue the results it causes
  task automatic predict_action(input action_t act, input logic [CNT_W-1:0] pos,
                                input logic signed [VAL_W-1:0] val);
    status_t     st;
    int unsigned i;
    st = ST_OK;
    case (act)
      ACT_APPEND: begin
        if (!shadow_grow() || shadow_count >= DEPTH) begin
          st = ST_FULL;
        end else begin
          shadow_mem[shadow_count] = val;
          shadow_count++;
        end
      end
      ACT_REMOVE: begin
        if (shadow_count == 0) st = ST_EMPTY;
        else shadow_count--;
      end
      ACT_INSERT: begin
        // position check comes before the full check
        if (pos > shadow_count) begin
          st = ST_BADPOS;
        end else if (!shadow_grow() || shadow_count >= DEPTH) begin
          st = ST_FULL;
        end else begin
          for (i = shadow_count; i > pos; i--) shadow_mem[i] = shadow_mem[i-1];
          shadow_mem[pos] = val;
          shadow_count++;
        end
      end
      default: ;
    endcase
    if (act == ACT_DUMP && shadow_count != 0) begin
      for (i = 0; i < shadow_count; i++)
        pending_results.push_back(make_result(shadow_mem[i], 1'b1, ST_OK,
                                              i + 1 == shadow_count));
    end else begin
      pending_results.push_back(make_result('0, 1'b0, st, 1'b1));
    end
  endtask

  // Offer one item and hold it until the transfer; called at a rising edge
  task automatic send_item(input action_t act, input logic [CNT_W-1:0] pos,
                           input logic signed [VAL_W-1:0] val);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_action   <= act;
    in_position <= pos;
    in_value    <= val;
    // inputs only move at rising edges, so the falling edge shows the coming transfer
    do @(negedge clk); while (!in_ready);
    predict_action(act, pos, val);
    @(posedge clk);
  endtask

  // Pause the sender until every queued result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Receiver: random stalls, or a long hold-off while hold_left runs down
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(negedge clk) begin : check_results
    vec_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, count", 32'(out_count), '0);
      end else begin
        want = pending_results.pop_front();
        if (out_element !== want.element)
          report_mismatch("element", out_element, want.element);
        if (out_element_valid !== want.element_valid)
          report_mismatch("element_valid", 32'(out_element_valid),
                          32'(want.element_valid));
        if (out_count !== want.count)
          report_mismatch("count", 32'(out_count), 32'(want.count));
        if (out_capacity_now !== want.capacity)
          report_mismatch("capacity_now", 32'(out_capacity_now), 32'(want.capacity));
        if (out_is_empty !== want.is_empty)
          report_mismatch("is_empty", 32'(out_is_empty), 32'(want.is_empty));
        if (out_status !== want.status)
          report_mismatch("status", 32'(out_status), 32'(want.status));
        if (out_last !== want.last)
          report_mismatch("last", 32'(out_last), 32'(want.last));
      end
    end
  end

  // Actions on an empty vector
  task automatic test_empty_cases();
    send_item(ACT_DUMP, 6'd0, '0);
    send_item(ACT_REMOVE, 6'd0, '0);
    send_item(ACT_INSERT, 6'd1, 32'sd5);
    send_item(ACT_INSERT, 6'd63, '1);
    drain_results();
  endtask

  // Append, insert at front, end and middle, remove, dump, growth to 8
  task automatic test_basic_ops();
    send_item(ACT_APPEND, 6'd0, 32'sh7fff_ffff);
    send_item(ACT_APPEND, 6'd63, 32'sh8000_0000);
    send_item(ACT_DUMP, 6'd0, '0);
    send_item(ACT_APPEND, 6'd0, '1);
    send_item(ACT_INSERT, 6'd0, '0);
    send_item(ACT_INSERT, 6'd4, 32'sh1234_5678);
    send_item(ACT_INSERT, 6'd2, -32'sd5);
    send_item(ACT_INSERT, 6'd7, 32'sd9);
    send_item(ACT_DUMP, 6'd0, '0);
    send_item(ACT_REMOVE, 6'd0, '0);
    send_item(ACT_REMOVE, 6'd32, '0);
    send_item(ACT_DUMP, 6'd0, '0);
    drain_results();
  endtask

  // Fill to the depth, hit full and bad position, empty it again
  task automatic test_growth_limit();
    while (shadow_count < DEPTH) send_item(ACT_APPEND, 6'd0, pick_value());
    send_item(ACT_APPEND, 6'd0, 32'sd1);
    send_item(ACT_INSERT, 6'd0, 32'sd2);
    send_item(ACT_INSERT, 6'd32, 32'sd3);
    send_item(ACT_INSERT, 6'd33, 32'sd4);
    send_item(ACT_INSERT, 6'd63, 32'sd5);
    send_item(ACT_DUMP, 6'd0, '0);
    while (shadow_count != 0) send_item(ACT_REMOVE, 6'($urandom_range(63)), '0);
    send_item(ACT_REMOVE, 6'd0, '0);
    send_item(ACT_DUMP, 6'd0, '0);
    send_item(ACT_APPEND, 6'd0, 32'sh5a5a_a5a5);
    drain_results();
  endtask

  // Receiver holds off while the sender keeps offering items
  task automatic test_backpressure();
    int k;
    in_idle_pct = 0;
    out_stall_pct <= 0;
    hold_left <= 300;
    for (k = 0; k < 8; k++) send_item(ACT_APPEND, 6'd0, pick_value());
    send_item(ACT_INSERT, 6'd0, pick_value());
    send_item(ACT_DUMP, 6'd0, '0);
    for (k = 0; k < 4; k++) send_item(ACT_REMOVE, 6'd0, '0);
    drain_results();
  endtask

  // Random mix; add_pct sets the share of appends and inserts
  task automatic test_random(input int n, input int idle_in, input int stall_out,
                             input int add_pct);
    int               k;
    int               p;
    action_t          act;
    logic [CNT_W-1:0] pos;
    in_idle_pct = idle_in;
    out_stall_pct <= stall_out;
    for (k = 0; k < n; k++) begin
      p = $urandom_range(99);
      if (p < add_pct / 2) act = ACT_APPEND;
      else if (p < add_pct) act = ACT_INSERT;
      else if (p < add_pct + 10) act = ACT_DUMP;
      else act = ACT_REMOVE;
      p = $urandom_range(9);
      if (act != ACT_INSERT || p == 0) pos = CNT_W'($urandom_range(63));
      else if (p == 1) pos = CNT_W'(shadow_count);
      else pos = CNT_W'($urandom_range(shadow_count));
      send_item(act, pos, pick_value());
    end
    drain_results();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_cases();
    test_basic_ops();
    test_growth_limit();
    test_backpressure();
    test_random(60, 0, 0, 60);
    test_random(60, 47, 0, 70);
    test_random(60, 0, 47, 50);
    test_random(60, 32, 32, 60);
    // stray results would show up here
    repeat (100) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[bounded_vector_insert_append.f]
src/bvi_pkg.sv
src/bvi_seq.sv
src/bvi_dpath.sv
src/bounded_vector_insert_append.sv
src/bvi_chk.sv
sim/testbench.sv
